// ----- sv/bbt_pkg.sv -----
// Shared types, geometry constants and helper functions for the buddy bitmap tree.
// Used by bbt_index, bbt_ram and buddy_bitmap_tree; depends on nothing.
`default_nettype none
package bbt_pkg;

  localparam int MAX_PAGES  = 4096;
  localparam int MAX_LEVELS = 13;
  localparam int WORD_BITS  = 32;
  localparam int NUM_WORDS  = 2 * MAX_PAGES / WORD_BITS;
  localparam int WADDR_W    = $clog2(NUM_WORDS);
  localparam int BSEL_W     = $clog2(WORD_BITS);
  localparam int LVL_W      = 4;
  localparam int POS_W      = 13;

  localparam logic [2:0] OP_SET_DIRTY = 3'd0;
  localparam logic [2:0] OP_CLR_DIRTY = 3'd1;
  localparam logic [2:0] OP_SET_SAT   = 3'd2;
  localparam logic [2:0] OP_CLR_SAT   = 3'd3;
  localparam logic [2:0] OP_SEARCH    = 3'd4;

  localparam logic       CFG_LEVEL_COUNT = 1'b0;
  localparam logic       CFG_PAGE_COUNT  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_RD,
    ST_UPD,
    ST_DONE
  } state_t;

  // Location of one tree bit inside the packed word store.
  typedef struct packed {
    logic [WADDR_W-1:0] word;
    logic [BSEL_W-1:0]  bsel;
    logic               inrange;
    logic               twin_inrange;
  } loc_t;

  // First bit of order k: the orders are packed one after another.
  function automatic logic [POS_W-1:0] base_of(input logic [LVL_W-1:0] k);
    logic [POS_W:0] full;
    full = (POS_W+1)'(2 * MAX_PAGES);
    return POS_W'(full - (full >> k));
  endfunction

endpackage
`default_nettype wire

// ----- sv/bbt_index.sv -----
// Shared index unit: maps an order and a block index to a word address and bit select.
// Depends on bbt_pkg.
`default_nettype none
module bbt_index (
  input  wire logic [bbt_pkg::LVL_W-1:0] lvl,
  input  wire logic [bbt_pkg::POS_W-1:0] pos,
  output bbt_pkg::loc_t                  loc
);
  import bbt_pkg::*;

  logic             lvl_ok;
  logic [POS_W-1:0] cap;
  logic [POS_W-1:0] idx;
  logic [POS_W-1:0] twin;

  always_comb begin
    lvl_ok = (lvl < LVL_W'(MAX_LEVELS));
    cap    = POS_W'(MAX_PAGES) >> (lvl_ok ? lvl : '0);
    twin   = pos ^ POS_W'(1);
    idx    = base_of(lvl_ok ? lvl : '0) + pos;
    loc.word         = idx[POS_W-1:BSEL_W];
    loc.bsel         = idx[BSEL_W-1:0];
    loc.inrange      = lvl_ok && (pos < cap);
    loc.twin_inrange = lvl_ok && (twin < cap);
  end

endmodule
`default_nettype wire

// ----- sv/bbt_ram.sv -----
// Single-port bitmap word store with registered read data.
// Depends on bbt_pkg.
`default_nettype none
module bbt_ram (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [bbt_pkg::WADDR_W-1:0]   addr,
  input  wire logic [bbt_pkg::WORD_BITS-1:0] wdata,
  output logic      [bbt_pkg::WORD_BITS-1:0] rdata
);
  import bbt_pkg::*;

  logic [WORD_BITS-1:0] mem [NUM_WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// ----- sv/buddy_bitmap_tree.sv -----
// Buddy bitmap tree: dirty and saturated per-order bitmaps with mark, clear and search.
// After reset the block clears all 256 words of both stores and is not ready meanwhile.
// A mark or clear walks up the orders, one order per step; a search examines one block
// per step. Each step is one read and one update of the single-port word stores, and
// the next item is accepted once the result has moved to the output register.
// Depends on bbt_pkg, bbt_index and bbt_ram.
`default_nettype none
module buddy_bitmap_tree (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // level, position, start_level, target_level, range_begin, range_end
  input  wire logic [55:0] s_tdata,
  // opcode
  input  wire logic [2:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // found_position
  output logic      [15:0] m_tdata,
  // found
  output logic             m_tuser,
  input  wire logic        cfg_we,
  input  wire logic        cfg_addr,
  input  wire logic [12:0] cfg_wdata
);
  import bbt_pkg::*;

  state_t state, state_next;

  logic [3:0]           level_count;
  logic [12:0]          page_count;
  logic [WADDR_W-1:0]   clr_cnt;
  logic [2:0]           op;
  logic [LVL_W-1:0]     cur_lvl;
  logic [POS_W-1:0]     cur_pos;
  logic [LVL_W-1:0]     tgt;
  logic [POS_W:0]       rng_e;
  loc_t                 loc_r;
  logic                 res_found;
  logic [11:0]          res_pos;

  logic [LVL_W-1:0]     n_eff;
  logic [POS_W-1:0]     pc_eff;
  loc_t                 loc;
  logic [WADDR_W-1:0]   ram_addr;
  logic                 d_we, s_we;
  logic [WORD_BITS-1:0] d_rdata, s_rdata, d_wdata, s_wdata;

  logic [2:0]           in_op;
  logic [LVL_W-1:0]     in_level, in_start, in_target;
  logic [11:0]          in_pos;
  logic [POS_W-1:0]     in_begin, in_end;

  function automatic logic [POS_W:0] blocks_of(input logic [POS_W-1:0] pc,
                                               input logic [LVL_W-1:0] k);
    logic [POS_W:0] sum;
    sum = {1'b0, pc} + (((POS_W+1)'(1)) << k) - (POS_W+1)'(1);
    return sum >> k;
  endfunction

  assign in_op     = s_tuser;
  assign in_level  = s_tdata[3:0];
  assign in_pos    = s_tdata[15:4];
  assign in_start  = s_tdata[19:16];
  assign in_target = s_tdata[23:20];
  assign in_begin  = s_tdata[36:24];
  assign in_end    = s_tdata[49:37];

  assign n_eff  = (level_count > LVL_W'(MAX_LEVELS)) ? LVL_W'(MAX_LEVELS) : level_count;
  assign pc_eff = (page_count > POS_W'(MAX_PAGES)) ? POS_W'(MAX_PAGES) : page_count;

  bbt_index u_index (
    .lvl (cur_lvl),
    .pos (cur_pos),
    .loc (loc)
  );

  // Working signals of the update step.
  logic           is_mark, is_dirty_op, bit_val, cont, sat, dty;
  logic [POS_W:0] nb, ne, lim_in, end_in, np;

  always_comb begin
    is_mark     = (op != OP_SEARCH);
    is_dirty_op = (op == OP_SET_DIRTY) || (op == OP_CLR_DIRTY);
    bit_val     = (op == OP_SET_DIRTY) || (op == OP_SET_SAT);
    d_wdata     = d_rdata;
    s_wdata     = s_rdata;
    d_wdata[loc_r.bsel] = bit_val;
    s_wdata[loc_r.bsel] = bit_val;
    d_we = 1'b0;
    s_we = 1'b0;
    if (state == ST_CLR) begin
      d_we    = 1'b1;
      s_we    = 1'b1;
      d_wdata = '0;
      s_wdata = '0;
    end else if (state == ST_UPD && is_mark && loc_r.inrange) begin
      d_we = is_dirty_op;
      s_we = !is_dirty_op;
    end
    unique case (state)
      ST_CLR:  ram_addr = clr_cnt;
      ST_UPD:  ram_addr = loc_r.word;
      default: ram_addr = loc.word;
    endcase

    case (op)
      OP_CLR_DIRTY: cont = !(loc_r.twin_inrange && d_rdata[loc_r.bsel ^ BSEL_W'(1)]);
      OP_SET_SAT:   cont = loc_r.twin_inrange && s_rdata[loc_r.bsel ^ BSEL_W'(1)];
      default:      cont = 1'b1;
    endcase

    sat    = loc_r.inrange && s_rdata[loc_r.bsel];
    dty    = loc_r.inrange && d_rdata[loc_r.bsel];
    nb     = {1'b0, cur_pos[POS_W-2:0], 1'b0};
    lim_in = blocks_of(pc_eff, (cur_lvl == '0) ? '0 : cur_lvl - LVL_W'(1));
    ne     = ((nb + (POS_W+1)'(2)) > lim_in) ? lim_in : nb + (POS_W+1)'(2);
    np     = {1'b0, cur_pos} + (POS_W+1)'(1);
    end_in = ({1'b0, in_end} > blocks_of(pc_eff, in_start)) ?
             blocks_of(pc_eff, in_start) : {1'b0, in_end};
  end

  bbt_ram u_dirty (
    .clk   (clk),
    .we    (d_we),
    .addr  (ram_addr),
    .wdata (d_wdata),
    .rdata (d_rdata)
  );

  bbt_ram u_sat (
    .clk   (clk),
    .we    (s_we),
    .addr  (ram_addr),
    .wdata (s_wdata),
    .rdata (s_rdata)
  );

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLR: begin
        if (clr_cnt == WADDR_W'(NUM_WORDS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          if (in_op == OP_SEARCH) begin
            state_next = (in_start >= n_eff || {1'b0, in_begin} >= end_in) ? ST_DONE : ST_RD;
          end else if (in_op < OP_SEARCH) begin
            state_next = (in_level >= n_eff) ? ST_DONE : ST_RD;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_RD: state_next = ST_UPD;
      ST_UPD: begin
        if (is_mark) begin
          state_next = (cont && (cur_lvl + LVL_W'(1) < n_eff)) ? ST_RD : ST_DONE;
        end else if (!sat && cur_lvl > tgt) begin
          state_next = (nb >= ne) ? ST_DONE : ST_RD;
        end else if (!sat && cur_lvl == tgt && !dty) begin
          state_next = ST_DONE;
        end else begin
          state_next = (np >= rng_e) ? ST_DONE : ST_RD;
        end
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level_count <= 4'd13;
      page_count  <= 13'd4096;
      clr_cnt     <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == CFG_LEVEL_COUNT) level_count <= cfg_wdata[3:0];
        else                             page_count  <= cfg_wdata;
      end
      if (state == ST_CLR) clr_cnt <= clr_cnt + WADDR_W'(1);
      if (state == ST_DONE && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tready)                               m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!m_tvalid || m_tready)) begin
      m_tdata <= {4'b0000, res_pos};
      m_tuser <= res_found;
    end
    unique case (state)
      ST_IDLE: begin
        op        <= in_op;
        tgt       <= in_target;
        rng_e     <= end_in;
        res_found <= 1'b0;
        res_pos   <= '0;
        if (in_op == OP_SEARCH) begin
          cur_lvl <= in_start;
          cur_pos <= in_begin;
        end else begin
          cur_lvl <= in_level;
          cur_pos <= {1'b0, in_pos};
        end
      end
      ST_RD: loc_r <= loc;
      ST_UPD: begin
        if (is_mark) begin
          cur_lvl <= cur_lvl + LVL_W'(1);
          cur_pos <= cur_pos >> 1;
        end else if (!sat && cur_lvl > tgt) begin
          cur_lvl <= cur_lvl - LVL_W'(1);
          cur_pos <= nb[POS_W-1:0];
          rng_e   <= ne;
        end else if (!sat && cur_lvl == tgt && !dty) begin
          res_found <= 1'b1;
          res_pos   <= cur_pos[11:0];
        end else begin
          cur_pos <= np[POS_W-1:0];
        end
      end
      default: ;
    endcase
  end

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLR |-> !s_tready)
    else $error("request accepted during clearing pass");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request accepted while busy");

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[11:0] == 12'd0)
    else $error("position nonzero on a not-found result");

  a_write_only_in_update: assert property (@(posedge clk) disable iff (rst)
    (d_we || s_we) |-> (state == ST_CLR || state == ST_UPD))
    else $error("store written outside clear or update");

endmodule
`default_nettype wire
